// ===== hdl/rtr_pkg.sv =====
`timescale 1ns / 1ps

package rtr_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SCREEN_W    = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    // Divider geometry: dividend covers a 12 x 10 bit product, divisor a 12-bit span.
    localparam int DIV_N_W     = 22;
    localparam int DIV_D_W     = 12;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_ITERS   = DIV_N_W / DIV_STEPS;
    localparam int DIV_ITER_W  = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [SAMPLE_W-1:0] STABLE_DIFF = 12'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_THRESHOLD = 3'd0,
        REG_X_RAW_MIN       = 3'd1,
        REG_X_RAW_MAX       = 3'd2,
        REG_Y_RAW_MIN       = 3'd3,
        REG_Y_RAW_MAX       = 3'd4,
        REG_X_OUT_MAX       = 3'd5,
        REG_Y_OUT_MAX       = 3'd6
    } t_reg_idx;

    // What the front part found at the end of one averaging group.
    typedef enum logic [1:0] {
        K_X1_EXIT = 2'd0,
        K_X1_KEEP = 2'd1,
        K_Y       = 2'd2,
        K_X2      = 2'd3
    } t_kind;

    typedef struct packed {
        logic [SAMPLE_W-1:0] press_threshold;
        logic [SAMPLE_W-1:0] x_raw_min;
        logic [SAMPLE_W-1:0] x_raw_max;
        logic [SAMPLE_W-1:0] y_raw_min;
        logic [SAMPLE_W-1:0] y_raw_max;
        logic [SCREEN_W-1:0] x_out_max;
        logic [SCREEN_W-1:0] y_out_max;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hdl/resistive_touch_reader_top.sv =====
`timescale 1ns / 1ps

// Four-wire resistive touch reader.
// Input channel (i_in_valid, o_in_stall, i_sample) carries one converter sample per
// transaction. Samples are averaged in groups of SAMPLES, in the order first X, Y and
// second X. A first X below the press threshold ends the sequence at once with a
// not-pressed result; otherwise the second X closes it with one result.
// Output channel (o_out_valid, i_out_stall and the result fields) carries one result
// per transaction. Configuration is written through i_cfg_valid / o_cfg_ready with a
// register index and data; ready is always high, and writes are meant for idle times.
// A sample is taken whenever the four-entry group queue is not full, so input
// throughput is one sample per cycle in bursts. The back end averages a finished
// group by a reciprocal multiplication. A second X group that divides both
// coordinates keeps it busy for up to one division per coordinate in the two-bit-per-cycle
// divider. From the last sample of a sequence, an early exit reaches o_out_valid
// through the averaging and emit states, a full touch also through mapping and division.
// A stalled result stays in the output register; the back end finishes the next
// result and holds it until the register frees, while the front keeps taking samples
// until the queue fills. Synchronous reset restores the register defaults, drops any
// partial group and queued work, and restarts with the first X phase.
module resistive_touch_reader_top #(
    parameter int SAMPLES = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [rtr_pkg::SAMPLE_W-1:0]       i_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_pressed,
    output logic [rtr_pkg::SCREEN_W-1:0]       o_screen_x,
    output logic [rtr_pkg::SCREEN_W-1:0]       o_screen_y,
    output logic [rtr_pkg::SAMPLE_W-1:0]       o_raw_x_out,
    output logic [rtr_pkg::SAMPLE_W-1:0]       o_raw_y_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rtr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rtr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rtr_pkg::*;

    localparam int ACC_W = SAMPLE_W + $clog2(SAMPLES);
    localparam int Q_W   = ACC_W + 2;

    t_cfg             r_cfg;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    t_kind            push_kind;
    logic [ACC_W-1:0] push_sum;
    logic [Q_W-1:0]   q_head;
    t_kind            head_kind;

    // Configuration register file. Indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_threshold <= 12'd100;
            r_cfg.x_raw_min       <= 12'd0;
            r_cfg.x_raw_max       <= 12'd4095;
            r_cfg.y_raw_min       <= 12'd0;
            r_cfg.y_raw_max       <= 12'd4095;
            r_cfg.x_out_max       <= 10'd239;
            r_cfg.y_out_max       <= 10'd319;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PRESS_THRESHOLD: r_cfg.press_threshold <= i_cfg_data;
                REG_X_RAW_MIN:       r_cfg.x_raw_min       <= i_cfg_data;
                REG_X_RAW_MAX:       r_cfg.x_raw_max       <= i_cfg_data;
                REG_Y_RAW_MIN:       r_cfg.y_raw_min       <= i_cfg_data;
                REG_Y_RAW_MAX:       r_cfg.y_raw_max       <= i_cfg_data;
                REG_X_OUT_MAX:       r_cfg.x_out_max       <= i_cfg_data[SCREEN_W-1:0];
                REG_Y_OUT_MAX:       r_cfg.y_out_max       <= i_cfg_data[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    rtr_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_cfg.press_threshold),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_kind    (push_kind),
        .o_q_sum     (push_sum)
    );

    // Each queue entry holds one finished group: its kind and its raw sum.
    rtr_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({push_kind, push_sum}),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign head_kind = t_kind'(q_head[Q_W-1:ACC_W]);

    rtr_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_kind    (head_kind),
        .i_q_sum     (q_head[ACC_W-1:0]),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pressed   (o_pressed),
        .o_screen_x  (o_screen_x),
        .o_screen_y  (o_screen_y),
        .o_raw_x_out (o_raw_x_out),
        .o_raw_y_out (o_raw_y_out)
    );

endmodule

// ===== hdl/rtr_queue.sv =====
`timescale 1ns / 1ps

module rtr_queue #(
    parameter int DATA_W = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);
    import rtr_pkg::*;

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== hdl/rtr_front.sv =====
`timescale 1ns / 1ps

module rtr_front #(
    parameter int SAMPLES = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [rtr_pkg::SAMPLE_W-1:0]           i_threshold,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [rtr_pkg::SAMPLE_W-1:0]           i_sample,
    input  logic                                   i_q_full,
    output logic                                   o_q_push,
    output rtr_pkg::t_kind                         o_q_kind,
    output logic [rtr_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] o_q_sum
);
    import rtr_pkg::*;

    localparam int ACC_W = SAMPLE_W + $clog2(SAMPLES);
    localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    typedef enum logic [1:0] {
        PH_X1 = 2'd0,
        PH_Y  = 2'd1,
        PH_X2 = 2'd2
    } t_phase;

    t_phase           r_phase;
    logic [CNT_W-1:0] r_count;
    logic [ACC_W-1:0] r_acc;

    logic             accept;
    logic             last;
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] thresh_sum;
    logic             below;

    assign accept     = i_in_valid && !i_q_full;
    assign last       = (r_count == CNT_W'(SAMPLES - 1));
    assign sum        = r_acc + ACC_W'(i_sample);
    // floor(sum / SAMPLES) < threshold exactly when sum < threshold * SAMPLES.
    assign thresh_sum = ACC_W'(i_threshold) * ACC_W'(SAMPLES);
    assign below      = (sum < thresh_sum);

    always_comb begin
        case (r_phase)
            PH_Y:    o_q_kind = K_Y;
            PH_X2:   o_q_kind = K_X2;
            default: o_q_kind = below ? K_X1_EXIT : K_X1_KEEP;
        endcase
    end

    assign o_q_push   = accept && last;
    assign o_q_sum    = sum;
    assign o_in_stall = i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_X1;
            r_count <= '0;
            r_acc   <= '0;
        end else if (accept) begin
            if (last) begin
                r_count <= '0;
                r_acc   <= '0;
                unique case (r_phase)
                    PH_Y:    r_phase <= PH_X2;
                    PH_X2:   r_phase <= PH_X1;
                    default: r_phase <= below ? PH_X1 : PH_Y;
                endcase
            end else begin
                r_count <= r_count + 1'b1;
                r_acc   <= sum;
            end
        end
    end

endmodule

// ===== hdl/rtr_divider.sv =====
`timescale 1ns / 1ps

module rtr_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtr_pkg::t_div_req i_req,
    output rtr_pkg::t_div_rsp o_rsp
);
    import rtr_pkg::*;

    logic [DIV_D_W-1:0]    r_rem;
    logic [DIV_N_W-1:0]    r_quo;
    logic [DIV_D_W-1:0]    r_den;
    logic [DIV_ITER_W-1:0] r_iter;
    logic                  r_busy;
    logic                  r_done;

    logic [DIV_D_W-1:0]    n_rem;
    logic [DIV_N_W-1:0]    n_quo;
    logic [DIV_D_W:0]      shifted;

    // Restoring division, two quotient bits per cycle.
    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        shifted = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            shifted = {n_rem, n_quo[DIV_N_W-1]};
            n_quo   = {n_quo[DIV_N_W-2:0], 1'b0};
            if (shifted >= {1'b0, r_den}) begin
                shifted  = shifted - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = shifted[DIV_D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_iter <= DIV_ITER_W'(DIV_ITERS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_iter <= r_iter - 1'b1;
                if (r_iter == DIV_ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hdl/rtr_back.sv =====
`timescale 1ns / 1ps

module rtr_back #(
    parameter int SAMPLES = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rtr_pkg::t_cfg                          i_cfg,
    input  logic                                   i_q_empty,
    input  rtr_pkg::t_kind                         i_q_kind,
    input  logic [rtr_pkg::SAMPLE_W+$clog2(SAMPLES)-1:0] i_q_sum,
    output logic                                   o_q_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_pressed,
    output logic [rtr_pkg::SCREEN_W-1:0]           o_screen_x,
    output logic [rtr_pkg::SCREEN_W-1:0]           o_screen_y,
    output logic [rtr_pkg::SAMPLE_W-1:0]           o_raw_x_out,
    output logic [rtr_pkg::SAMPLE_W-1:0]           o_raw_y_out
);
    import rtr_pkg::*;

    localparam int ACC_W  = SAMPLE_W + $clog2(SAMPLES);
    // The group average is the sum times a rounded-up reciprocal of SAMPLES,
    // shifted down. With this shift the result is exact for every ACC_W-bit sum.
    localparam int RCP_SH = ACC_W + $clog2(SAMPLES);
    localparam int RCP_M  = ((1 << RCP_SH) + SAMPLES - 1) / SAMPLES;
    localparam int PROD_W = 2 * ACC_W + 1;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_AVG      = 3'd1,
        S_MAP      = 3'd2,
        S_MAP_WAIT = 3'd3,
        S_EMIT     = 3'd4
    } t_state;

    t_state              r_state;
    t_kind               r_kind;
    logic                r_axis;
    t_div_req            r_div_req;
    t_div_rsp            div_rsp;

    logic [SAMPLE_W-1:0] r_avg;
    logic [SAMPLE_W-1:0] r_first_x;
    logic [SAMPLE_W-1:0] r_held_y;
    logic [SAMPLE_W-1:0] r_x2;

    logic                r_pressed;
    logic [SCREEN_W-1:0] r_sx;
    logic [SCREEN_W-1:0] r_sy;
    logic [SAMPLE_W-1:0] r_rx;
    logic [SAMPLE_W-1:0] r_ry;

    logic                r_out_valid;
    logic                r_out_pressed;
    logic [SCREEN_W-1:0] r_out_sx;
    logic [SCREEN_W-1:0] r_out_sy;
    logic [SAMPLE_W-1:0] r_out_rx;
    logic [SAMPLE_W-1:0] r_out_ry;

    logic [PROD_W-1:0]   avg_prod;
    logic [SAMPLE_W-1:0] q_avg;
    logic [SAMPLE_W-1:0] avg;
    logic [SAMPLE_W-1:0] x_diff;
    logic                stable;

    logic [SAMPLE_W-1:0] m_raw;
    logic [SAMPLE_W-1:0] m_lo;
    logic [SAMPLE_W-1:0] m_hi;
    logic [SCREEN_W-1:0] m_top;
    logic [SAMPLE_W-1:0] m_span;
    logic [DIV_N_W-1:0]  m_prod;
    logic                m_clamp;
    logic [SCREEN_W-1:0] m_coord;

    rtr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    // Average of the group at the queue head.
    assign avg_prod = PROD_W'(i_q_sum) * PROD_W'(RCP_M);
    assign q_avg    = avg_prod[RCP_SH +: SAMPLE_W];

    // Average of a group and the stability check against the first X and the press threshold.
    assign avg    = r_avg;
    assign x_diff = (r_first_x > avg) ? (r_first_x - avg) : (avg - r_first_x);
    assign stable = (x_diff <= STABLE_DIFF) && (avg >= i_cfg.press_threshold);

    // Operands of the axis being mapped.
    assign m_raw   = r_axis ? r_held_y        : r_x2;
    assign m_lo    = r_axis ? i_cfg.y_raw_min : i_cfg.x_raw_min;
    assign m_hi    = r_axis ? i_cfg.y_raw_max : i_cfg.x_raw_max;
    assign m_top   = r_axis ? i_cfg.y_out_max : i_cfg.x_out_max;
    assign m_span  = m_raw - m_lo;
    assign m_prod  = DIV_N_W'(m_span) * DIV_N_W'(m_top);
    assign m_clamp = (m_raw <= m_lo) || (m_raw >= m_hi);

    always_comb begin
        if (m_raw <= m_lo) begin
            m_coord = '0;
        end else begin
            m_coord = m_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_kind          <= K_X1_KEEP;
            r_axis          <= 1'b0;
            r_div_req.start <= 1'b0;
            r_first_x       <= '0;
            r_held_y        <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_div_req.start <= (r_state == S_MAP) && !m_clamp;
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_kind  <= i_q_kind;
                        r_avg   <= q_avg;
                        r_state <= S_AVG;
                    end
                end

                S_AVG: begin
                    unique case (r_kind)
                        K_X1_EXIT: begin
                            r_first_x <= avg;
                            r_pressed <= 1'b0;
                            r_sx      <= '0;
                            r_sy      <= '0;
                            r_rx      <= avg;
                            r_ry      <= '0;
                            r_state   <= S_EMIT;
                        end
                        K_X1_KEEP: begin
                            r_first_x <= avg;
                            r_state   <= S_IDLE;
                        end
                        K_Y: begin
                            r_held_y <= avg;
                            r_state  <= S_IDLE;
                        end
                        K_X2: begin
                            r_x2      <= avg;
                            r_rx      <= avg;
                            r_ry      <= r_held_y;
                            r_pressed <= stable;
                            r_sx      <= '0;
                            r_sy      <= '0;
                            r_axis    <= 1'b0;
                            r_state   <= stable ? S_MAP : S_EMIT;
                        end
                    endcase
                end

                S_MAP: begin
                    if (m_clamp) begin
                        if (r_axis) begin
                            r_sy    <= m_coord;
                            r_state <= S_EMIT;
                        end else begin
                            r_sx   <= m_coord;
                            r_axis <= 1'b1;
                        end
                    end else begin
                        r_div_req.dividend <= m_prod;
                        r_div_req.divisor  <= m_hi - m_lo;
                        r_state            <= S_MAP_WAIT;
                    end
                end

                S_MAP_WAIT: begin
                    if (div_rsp.done) begin
                        if (r_axis) begin
                            r_sy    <= div_rsp.quotient[SCREEN_W-1:0];
                            r_state <= S_EMIT;
                        end else begin
                            r_sx    <= div_rsp.quotient[SCREEN_W-1:0];
                            r_axis  <= 1'b1;
                            r_state <= S_MAP;
                        end
                    end
                end

                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid   <= 1'b1;
                        r_out_pressed <= r_pressed;
                        r_out_sx      <= r_sx;
                        r_out_sy      <= r_sy;
                        r_out_rx      <= r_rx;
                        r_out_ry      <= r_ry;
                        r_state       <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pressed   = r_out_pressed;
    assign o_screen_x  = r_out_sx;
    assign o_screen_y  = r_out_sy;
    assign o_raw_x_out = r_out_rx;
    assign o_raw_y_out = r_out_ry;

endmodule

// ===== hdl/rtr_checker.sv =====
`timescale 1ns / 1ps

module rtr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_pressed,
    input logic [rtr_pkg::SCREEN_W-1:0]       o_screen_x,
    input logic [rtr_pkg::SCREEN_W-1:0]       o_screen_y,
    input logic [rtr_pkg::SAMPLE_W-1:0]       o_raw_x_out,
    input logic [rtr_pkg::SAMPLE_W-1:0]       o_raw_y_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_pressed) && $stable(o_screen_x)
            && $stable(o_screen_y) && $stable(o_raw_x_out) && $stable(o_raw_y_out))
        else $error("stalled result changed");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pressed |-> (o_screen_x == '0) && (o_screen_y == '0))
        else $error("rejected touch carries screen coordinates");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind resistive_touch_reader_top rtr_checker u_rtr_checker (.*);
